@@ hw/rtl/rqr_pkg.sv @@
package rqr_pkg;

    localparam int ID_BITS    = 8;
    localparam int TYPE_BITS  = 3;
    localparam int STAT_BITS  = 2;
    localparam int COUNT_BITS = 5;

    typedef enum logic [TYPE_BITS-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_QUERY  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } stat_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0] req_type;
        logic [ID_BITS-1:0]   thread_id;
        logic [ID_BITS-1:0]   parent_id;
        logic                 parent_valid;
    } req_t;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [ID_BITS-1:0]    out_thread_id;
        logic [ID_BITS-1:0]    out_parent_id;
        logic                  out_parent_valid;
        logic [COUNT_BITS-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [ID_BITS-1:0] tid;
        logic [ID_BITS-1:0] pid;
        logic               pflag;
    } entry_t;

    typedef struct packed {
        logic               capture;
        logic               apply;
        op_t                op;
        logic [ID_BITS-1:0] key;
        entry_t             fill;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/ready_queue_with_remove_core.sv @@
// Ordered ready queue of thread entries held in a row of cells, head in cell 0.
// Request channel: req_valid / req_ready carrying req (type, thread id, parent
// id, parent flag). Response channel: rsp_valid / rsp_ready carrying rsp
// (status, taken entry, entry count after the request).
// Every request gives exactly one response item.
// An accepted request is registered and run in the execute state, which
// loads the response register; no new request is taken before it returns
// to idle. Accepting a request latches per-cell id compares; the execute
// state ripples the first-match flag down the cell row and shifts the cells
// behind a taken entry toward the head.
// A new request is taken while the previous response is being taken in the
// same cycle; if the receiver stalls, the response register holds its item
// and req_ready stays low until it is taken.
// Reset empties the queue (all cell valid bits and the count clear) and
// drops any pending response; entry contents are left as they are.
module ready_queue_with_remove_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rqr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rqr_pkg::rsp_t rsp
);
    import rqr_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    req_t               req_reg;
    req_t               req_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               capture;
    logic               apply;
    op_t                op_cur;
    cell_ctrl_t         ctrl;
    entry_t             fill;

    entry_t             cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_take;
    logic [QUEUE_DEPTH:0]   seen;
    entry_t             sel_entry;
    logic               found;
    logic               full;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req_valid && req_ready) state_next = S_EXEC;
            S_EXEC: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready = 1'b0;
        apply     = 1'b0;
        unique case (state_reg)
            S_IDLE: req_ready = !rsp_valid_reg || rsp_ready;
            S_EXEC: apply = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign capture = req_valid && req_ready;
    assign op_cur  = capture ? op_t'(req.req_type) : op_t'(req_reg.req_type);

    always_comb
    begin
        fill.tid   = req_reg.thread_id;
        fill.pid   = req_reg.parent_valid ? req_reg.parent_id : '0;
        fill.pflag = req_reg.parent_valid;
    end

    always_comb
    begin
        ctrl.capture = capture;
        ctrl.apply   = apply;
        ctrl.op      = op_cur;
        ctrl.key     = capture ? req.thread_id : req_reg.thread_id;
        ctrl.fill    = fill;
    end

    assign seen[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic   prev_valid;
            entry_t next_entry;
            logic   next_valid;

            if (gi == 0)
            begin : g_head
                assign prev_valid = 1'b1;
            end
            else
            begin : g_body
                assign prev_valid = cell_valid[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_entry = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_link
                assign next_entry = cell_entry[gi+1];
                assign next_valid = cell_valid[gi+1];
            end

            rqr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_valid (prev_valid),
                .seen_in    (seen[gi]),
                .next_entry (next_entry),
                .next_valid (next_valid),
                .entry      (cell_entry[gi]),
                .valid      (cell_valid[gi]),
                .seen_out   (seen[gi+1]),
                .take       (cell_take[gi])
            );
        end
    endgenerate

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            sel_entry = entry_t'(sel_entry | (cell_take[i] ? cell_entry[i] : '0));
        end
    end

    assign found = seen[QUEUE_DEPTH];
    assign full  = cell_valid[QUEUE_DEPTH-1];

    always_comb
    begin
        count_next                = count_reg;
        rsp_next                  = '0;
        rsp_next.status           = STAT_OK;
        unique case (op_t'(req_reg.req_type)) inside
            OP_PUSH:
            begin
                if (full)
                    rsp_next.status = STAT_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            OP_POP, OP_REMOVE:
            begin
                if (found)
                begin
                    rsp_next.out_thread_id    = sel_entry.tid;
                    rsp_next.out_parent_id    = sel_entry.pid;
                    rsp_next.out_parent_valid = sel_entry.pflag;
                    count_next                = count_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status = STAT_MISS;
                end
            end
            OP_QUERY:
            begin
                if (!found)
                    rsp_next.status = STAT_MISS;
            end
            default:
            begin
            end
        endcase
        rsp_next.entry_count = COUNT_BITS'(count_next);
    end

    always_comb
    begin
        req_next = capture ? req : req_reg;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (apply)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (apply)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (apply)
            rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == 32'($countones(cell_valid)))
        else $error("entry count differs from occupied cells");

    a_cells_compacted: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + 1'b1) & cell_valid) == '0)
        else $error("occupied cells are not packed at the head");

    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        apply |-> $onehot0(cell_take))
        else $error("more than one cell taken");

    a_exec_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_EXEC))
        else $error("accepted item not executed next cycle");

    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        apply |=> rsp_valid)
        else $error("response not raised after execute");
`endif

endmodule

@@ hw/rtl/rqr_cell.sv @@
module rqr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rqr_pkg::cell_ctrl_t ctrl,
    input  logic               prev_valid,
    input  logic               seen_in,
    input  rqr_pkg::entry_t    next_entry,
    input  logic               next_valid,
    output rqr_pkg::entry_t    entry,
    output logic               valid,
    output logic               seen_out,
    output logic               take
);
    import rqr_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;
    logic   match_reg;
    logic   match_next;

    assign entry    = entry_reg;
    assign valid    = valid_reg;
    assign seen_out = seen_in | match_reg;
    assign take     = match_reg & ~seen_in;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            case (ctrl.op)
                OP_POP:    match_next = valid_reg;
                OP_QUERY:  match_next = valid_reg && (entry_reg.tid == ctrl.key);
                OP_REMOVE: match_next = valid_reg && (entry_reg.tid == ctrl.key);
                default:   match_next = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.apply)
        begin
            case (ctrl.op)
                OP_PUSH:
                begin
                    if (!valid_reg && prev_valid)
                    begin
                        entry_next = ctrl.fill;
                        valid_next = 1'b1;
                    end
                end
                OP_POP, OP_REMOVE:
                begin
                    // advance the tail toward the head past the taken item
                    if (seen_in || match_reg)
                    begin
                        entry_next = next_entry;
                        valid_next = next_valid;
                    end
                end
                OP_CLEAR:
                begin
                    if (valid_reg && entry_reg.pflag && (entry_reg.pid == ctrl.key))
                    begin
                        entry_next.pflag = 1'b0;
                        entry_next.pid   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ bench/rqr_response_check.sv @@
`timescale 1ns / 1ps

module rqr_response_check #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  rqr_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  rqr_pkg::rsp_t rsp,
    output int            fail_count,
    output int            outstanding,
    output int            req_total,
    output int            rsp_total,
    output int            full_drops,
    output int            remove_hits
);
    import rqr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    entry_t slots [QUEUE_DEPTH];
    int     queue_len;
    int     reported;
    rsp_t   expected_rsp [$];

    function automatic int find_entry(logic [ID_BITS-1:0] id);
        for (int i = 0; i < queue_len; i++)
        begin
            if (slots[i].tid == id)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic rsp_t take_entry(int k);
        rsp_t res;
        res = '0;
        res.out_thread_id    = slots[k].tid;
        res.out_parent_id    = slots[k].pid;
        res.out_parent_valid = slots[k].pflag;
        for (int i = k; i < queue_len - 1; i++)
        begin
            slots[i] = slots[i + 1];
        end
        queue_len--;
        return res;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int   k;
        res = '0;
        case (r.req_type)
            OP_PUSH:
            begin
                if (queue_len >= QUEUE_DEPTH)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    slots[queue_len].tid   = r.thread_id;
                    slots[queue_len].pid   = r.parent_valid ? r.parent_id : '0;
                    slots[queue_len].pflag = r.parent_valid;
                    queue_len++;
                end
            end
            OP_POP:
            begin
                if (queue_len == 0)
                begin
                    res.status = STAT_MISS;
                end
                else
                begin
                    res = take_entry(0);
                end
            end
            OP_QUERY:
            begin
                if (find_entry(r.thread_id) < 0)
                begin
                    res.status = STAT_MISS;
                end
            end
            OP_REMOVE:
            begin
                k = find_entry(r.thread_id);
                if (k < 0)
                begin
                    res.status = STAT_MISS;
                end
                else
                begin
                    res = take_entry(k);
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < queue_len; i++)
                begin
                    if (slots[i].pflag && slots[i].pid == r.thread_id)
                    begin
                        slots[i].pflag = 1'b0;
                        slots[i].pid   = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = COUNT_BITS'(queue_len);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            queue_len = 0;
            reported  = 0;
            expected_rsp.delete();
            fail_count  = 0;
            outstanding = 0;
            req_total   = 0;
            rsp_total   = 0;
            full_drops  = 0;
            remove_hits = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_total++;
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (reported < REPORT_LIMIT)
                    begin
                        $display("unexpected response item: st=%0d tid=%02h pid=%02h pv=%0d cnt=%0d",
                                 rsp.status, rsp.out_thread_id, rsp.out_parent_id,
                                 rsp.out_parent_valid, rsp.entry_count);
                    end
                    reported++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp !== want)
                    begin
                        fail_count++;
                        if (reported < REPORT_LIMIT)
                        begin
                            $display("response %0d: expected st=%0d tid=%02h pid=%02h pv=%0d cnt=%0d",
                                     rsp_total, want.status, want.out_thread_id,
                                     want.out_parent_id, want.out_parent_valid,
                                     want.entry_count);
                            $display("response %0d:   actual st=%0d tid=%02h pid=%02h pv=%0d cnt=%0d",
                                     rsp_total, rsp.status, rsp.out_thread_id,
                                     rsp.out_parent_id, rsp.out_parent_valid,
                                     rsp.entry_count);
                        end
                        reported++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                req_total++;
                want = apply_request(req);
                if (req.req_type == OP_PUSH && want.status == STAT_FULL)
                begin
                    full_drops++;
                end
                if (req.req_type == OP_REMOVE && want.status == STAT_OK)
                begin
                    remove_hits++;
                end
                expected_rsp.push_back(want);
            end
            outstanding = expected_rsp.size();
        end
    end

endmodule

@@ bench/tb_ready_queue_with_remove_core.sv @@
`timescale 1ns / 1ps

module tb_ready_queue_with_remove_core;
    import rqr_pkg::*;

    localparam int DEPTH           = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 150;

    localparam logic [TYPE_BITS-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [TYPE_BITS-1:0] OP_RSVD_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int send_idle_pct;
    int rcv_idle_pct;
    int cycle_count;
    int fail_count;
    int outstanding;
    int req_total;
    int rsp_total;
    int full_drops;
    int remove_hits;

    logic [ID_BITS-1:0] id_pool [8];

    ready_queue_with_remove_core #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    rqr_response_check #(
        .QUEUE_DEPTH(DEPTH)
    ) response_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .outstanding(outstanding),
        .req_total  (req_total),
        .rsp_total  (rsp_total),
        .full_drops (full_drops),
        .remove_hits(remove_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL ready_queue_with_remove_core");
            $finish;
        end
    end

    function automatic req_t make_req(logic [TYPE_BITS-1:0] op, logic [ID_BITS-1:0] tid,
                                      logic [ID_BITS-1:0] pid, logic pv);
        req_t r;
        r.req_type     = op;
        r.thread_id    = tid;
        r.parent_id    = pid;
        r.parent_valid = pv;
        return r;
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id();
        if ($urandom_range(3) == 0)
        begin
            return ID_BITS'($urandom);
        end
        return id_pool[$urandom_range(7)];
    endfunction

    task automatic send_item(input req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int                   push_pct;
        logic [TYPE_BITS-1:0] op;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_ready     = 1'b0;
        send_idle_pct = 6;
        rcv_idle_pct  = 57;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(make_req(OP_POP, 8'h00, 8'h00, 1'b0));
        send_item(make_req(OP_QUERY, 8'hFF, 8'h00, 1'b0));
        send_item(make_req(OP_REMOVE, 8'h00, 8'hFF, 1'b1));
        send_item(make_req(OP_CLEAR, 8'h00, 8'hFF, 1'b1));
        send_item(make_req(OP_RSVD_HI, 8'hFF, 8'hFF, 1'b1));
        for (int i = 0; i < DEPTH; i++)
        begin
            send_item(make_req(OP_PUSH, (i % 4 == 2) ? 8'hA5 : ID_BITS'(i * 17),
                               (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h30),
                               i[0]));
        end
        send_item(make_req(OP_PUSH, 8'h5A, 8'hFF, 1'b1));
        send_item(make_req(OP_QUERY, 8'hFF, 8'h00, 1'b0));
        send_item(make_req(OP_REMOVE, 8'hA5, 8'h00, 1'b0));
        send_item(make_req(OP_CLEAR, 8'h00, 8'h00, 1'b0));
        send_item(make_req(OP_CLEAR, 8'h30, 8'h00, 1'b0));
        send_item(make_req(OP_POP, 8'h00, 8'h00, 1'b0));

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 6;
                    rcv_idle_pct  = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    rcv_idle_pct  = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                end
            endcase
            foreach (id_pool[k])
            begin
                id_pool[k] = ID_BITS'($urandom);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // alternate filling and draining stretches
                push_pct = ((n / 40) % 2 == 0) ? 60 : 20;
                if ($urandom_range(99) < push_pct)
                begin
                    op = OP_PUSH;
                end
                else
                begin
                    case ($urandom_range(99)) inside
                        [0:24]:  op = OP_POP;
                        [25:49]: op = OP_QUERY;
                        [50:79]: op = OP_REMOVE;
                        [80:93]: op = OP_CLEAR;
                        default: op = TYPE_BITS'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
                    endcase
                end
                send_item(make_req(op, pick_id(), pick_id(), 1'($urandom)));
            end
        end

        req_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);

        $display("%0d requests sent, %0d responses checked in order", req_total, rsp_total);
        $display("%0d pushes dropped on a full queue, %0d removes found their id",
                 full_drops, remove_hits);
        if (fail_count == 0)
        begin
            $display("PASS ready_queue_with_remove_core");
        end
        else
        begin
            $display("FAIL ready_queue_with_remove_core");
        end
        $finish;
    end

endmodule
